/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the projection block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge, off while reset is high
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequence checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/wtsp_pkg.sv */
// ----------------------------------------------------------------------------
// wtsp_pkg
// types and constants of the world to screen projection pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package wtsp_pkg;

   localparam int COORD_W    = 32;
   localparam int COEF_W     = 32;
   localparam int DIM_W      = 14;
   localparam int FRAC_W     = 12;
   localparam int DIM_SHIFT  = 11;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   // raised y * coefficient
   localparam int PROD_W  = COORD_W + 1 + COEF_W;
   localparam int CLIP_W  = 56;
   localparam int ABS_W   = CLIP_W - 1;
   localparam int SCALE_W = DIM_W + DIM_SHIFT;
   localparam int NUM_W   = ABS_W + SCALE_W;
   localparam int QUOT_W  = 41;
   localparam int DIV_LAT = QUOT_W + 2;

   localparam logic [QUOT_W-1:0] QUOT_CAP = QUOT_W'(1) << (QUOT_W - 1);

   localparam logic [1:0] OP_POINT = 2'd0;
   localparam logic [1:0] OP_LABEL = 2'd1;
   localparam logic [1:0] OP_BOX   = 2'd2;

   localparam logic signed [COORD_W:0] RAISE_LABEL = 33'sd7373;
   localparam logic signed [COORD_W:0] RAISE_BOX   = 33'sd8192;

   localparam logic [CSR_IDX_W-1:0] CSR_XROW_A  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_XROW_B  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_YROW_A  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_YROW_B  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WROW_A  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_WROW_B  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT  = 3'd7;

   typedef struct packed {
      logic [1:0]                 op;
      logic signed [COORD_W-1:0]  world_x;
      logic signed [COORD_W-1:0]  world_y;
      logic signed [COORD_W-1:0]  world_z;
   } req_type;

   typedef struct packed {
      logic                       visible;
      logic signed [COORD_W-1:0]  screen_x;
      logic signed [COORD_W-1:0]  screen_y;
      logic signed [COORD_W-1:0]  upper_y;
      logic signed [COORD_W-1:0]  box_left;
      logic signed [COORD_W-1:0]  box_width;
      logic signed [COORD_W-1:0]  box_height;
   } rsp_type;

endpackage

`default_nettype wire

/* rtl/wtsp_div.sv */
// ----------------------------------------------------------------------------
// wtsp_div
// pipelined restoring divider, one quotient bit per stage, capped and signed
// ----------------------------------------------------------------------------
`default_nettype none

module wtsp_div (
   input  wire logic                            clock,
   input  wire logic                            en,
   input  wire logic [wtsp_pkg::NUM_W-1:0]      num,
   input  wire logic [wtsp_pkg::ABS_W-1:0]      den,
   input  wire logic                            neg,
   output logic signed [wtsp_pkg::QUOT_W:0]     quot
);
   import wtsp_pkg::*;

   logic [ABS_W-1:0]  rem_ff  [0:QUOT_W];
   logic [ABS_W-1:0]  rem_in  [0:QUOT_W];
   logic [QUOT_W-1:0] low_ff  [0:QUOT_W];
   logic [QUOT_W-1:0] low_in  [0:QUOT_W];
   logic [QUOT_W-1:0] q_ff    [0:QUOT_W];
   logic [QUOT_W-1:0] q_in    [0:QUOT_W];
   logic [ABS_W-1:0]  den_ff  [0:QUOT_W];
   logic [ABS_W-1:0]  den_in  [0:QUOT_W];
   logic              ovf_ff  [0:QUOT_W];
   logic              ovf_in  [0:QUOT_W];
   logic              neg_ff  [0:QUOT_W];
   logic              neg_in  [0:QUOT_W];
   logic signed [QUOT_W:0] quot_ff;
   logic signed [QUOT_W:0] quot_in;

   always_comb begin
      logic [ABS_W:0]  rem2;
      logic            ge;
      logic [QUOT_W-1:0] qmag;
      // high part at or above the divisor means the quotient exceeds the cap
      rem_in[0] = ABS_W'(num[NUM_W-1:QUOT_W]);
      ovf_in[0] = (ABS_W'(num[NUM_W-1:QUOT_W]) >= den);
      low_in[0] = num[QUOT_W-1:0];
      q_in[0]   = '0;
      den_in[0] = den;
      neg_in[0] = neg;
      for (int i = 0; i < QUOT_W; i++) begin
         rem2 = {rem_ff[i], low_ff[i][QUOT_W-1-i]};
         ge   = (rem2 >= {1'b0, den_ff[i]});
         rem_in[i+1] = ge ? ABS_W'(rem2 - {1'b0, den_ff[i]}) : rem2[ABS_W-1:0];
         q_in[i+1]   = {q_ff[i][QUOT_W-2:0], ge};
         low_in[i+1] = low_ff[i];
         den_in[i+1] = den_ff[i];
         ovf_in[i+1] = ovf_ff[i];
         neg_in[i+1] = neg_ff[i];
      end
      qmag = (ovf_ff[QUOT_W] || (q_ff[QUOT_W] > QUOT_CAP)) ? QUOT_CAP : q_ff[QUOT_W];
      quot_in = neg_ff[QUOT_W] ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i <= QUOT_W; i++) begin
            rem_ff[i] <= rem_in[i];
            low_ff[i] <= low_in[i];
            q_ff[i]   <= q_in[i];
            den_ff[i] <= den_in[i];
            ovf_ff[i] <= ovf_in[i];
            neg_ff[i] <= neg_in[i];
         end
         quot_ff <= quot_in;
      end
   end

   assign quot = quot_ff;

endmodule

`default_nettype wire

/* rtl/world_to_screen_projection_unit.sv */
// ----------------------------------------------------------------------------
// world_to_screen_projection_unit
// perspective projection of world points to viewport coordinates
// ----------------------------------------------------------------------------
// a point (Q20.12) and a mode enter on the req_ channel; one result leaves on
// the rsp_ channel for every point, in order. a transfer happens on a rising
// edge with valid high and stall low.
// the matrix columns and viewport size are written through the csr_ port,
// which is always ready; write it only while no point is in flight.
// a point passes from a req_ transfer to rsp_valid of its result through
// seven stages of dot products and scaling, a 43 stage divider (one quotient
// bit per stage, three lanes for x, y and the raised y), then the viewport
// add and the box stage. one point is taken every cycle while req_stall is low.
// the whole pipe advances together; while rsp_valid is high and rsp_stall is
// high it holds and req_stall is raised, so nothing is dropped or repeated.
// reset clears all valid bits, sets the matrix to zero and the viewport to
// 1920 by 1080.
// ----------------------------------------------------------------------------
`default_nettype none

module world_to_screen_projection_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire wtsp_pkg::req_type                    req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output wtsp_pkg::rsp_type                         rsp_data,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [wtsp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [wtsp_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import wtsp_pkg::*;

`include "assert_macros.svh"

   localparam int PRE_LAT = 7;
   localparam int VLD_N   = PRE_LAT + DIV_LAT + 1;
   localparam int SPLIT_W = 28;
   localparam int LO_W    = SPLIT_W + SCALE_W;
   localparam int HI_W    = ABS_W - SPLIT_W + SCALE_W;
   localparam int SUM_W   = 44;
   localparam int LANES   = 3;

   typedef struct packed {
      logic [1:0] op;
      logic       vis;
   } side_type;

   function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
      logic hi_ones;
      logic hi_zero;
      hi_ones = &v[SUM_W-1:COORD_W-1];
      hi_zero = ~|v[SUM_W-1:COORD_W-1];
      if (hi_ones || hi_zero) begin
         return v[COORD_W-1:0];
      end
      return v[SUM_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
   endfunction

   // ---------------- configuration ----------------
   logic [CSR_DATA_W-1:0] xa_ff, xb_ff, ya_ff, yb_ff, wa_ff, wb_ff;
   logic [DIM_W-1:0]      wd_ff, ht_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         xa_ff <= '0;
         xb_ff <= '0;
         ya_ff <= '0;
         yb_ff <= '0;
         wa_ff <= '0;
         wb_ff <= '0;
         wd_ff <= DIM_W'(1920);
         ht_ff <= DIM_W'(1080);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_XROW_A: xa_ff <= csr_wdata;
            CSR_XROW_B: xb_ff <= csr_wdata;
            CSR_YROW_A: ya_ff <= csr_wdata;
            CSR_YROW_B: yb_ff <= csr_wdata;
            CSR_WROW_A: wa_ff <= csr_wdata;
            CSR_WROW_B: wb_ff <= csr_wdata;
            CSR_WIDTH:  wd_ff <= csr_wdata[DIM_W-1:0];
            CSR_HEIGHT: ht_ff <= csr_wdata[DIM_W-1:0];
            default:    ;
         endcase
      end
   end

   logic signed [COEF_W-1:0] m00, m10, m20, m30, m01, m11, m21, m31, m03, m13, m23, m33;
   assign m00 = xa_ff[COEF_W-1:0];
   assign m10 = xa_ff[2*COEF_W-1:COEF_W];
   assign m20 = xb_ff[COEF_W-1:0];
   assign m30 = xb_ff[2*COEF_W-1:COEF_W];
   assign m01 = ya_ff[COEF_W-1:0];
   assign m11 = ya_ff[2*COEF_W-1:COEF_W];
   assign m21 = yb_ff[COEF_W-1:0];
   assign m31 = yb_ff[2*COEF_W-1:COEF_W];
   assign m03 = wa_ff[COEF_W-1:0];
   assign m13 = wa_ff[2*COEF_W-1:COEF_W];
   assign m23 = wb_ff[COEF_W-1:0];
   assign m33 = wb_ff[2*COEF_W-1:COEF_W];

   // ---------------- flow control ----------------
   logic             adv;
   logic             rsp_valid_ff;
   logic [VLD_N-1:0] vld_ff;

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[VLD_N-2:0], req_valid};
         rsp_valid_ff <= vld_ff[VLD_N-1];
      end
   end

   // ---------------- s1: input register ----------------
   req_type s1_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff <= req_data;
      end
   end

   // ---------------- s2: products ----------------
   logic signed [COORD_W:0]  ry;
   logic signed [PROD_W-1:0] pw_in [0:2];
   logic signed [PROD_W-1:0] px_in [0:2];
   logic signed [PROD_W-1:0] py_in [0:2];
   logic signed [PROD_W-1:0] pu_in;
   logic signed [PROD_W-1:0] pw_ff [0:2];
   logic signed [PROD_W-1:0] px_ff [0:2];
   logic signed [PROD_W-1:0] py_ff [0:2];
   logic signed [PROD_W-1:0] pu_ff;
   logic [1:0]               s2_op_ff;

   always_comb begin
      ry = (s1_ff.op == OP_LABEL) ? (COORD_W+1)'(s1_ff.world_y) + RAISE_LABEL
                                  : (COORD_W+1)'(s1_ff.world_y) + RAISE_BOX;
      pw_in[0] = PROD_W'(s1_ff.world_x) * PROD_W'(m03);
      pw_in[1] = PROD_W'(s1_ff.world_y) * PROD_W'(m13);
      pw_in[2] = PROD_W'(s1_ff.world_z) * PROD_W'(m23);
      px_in[0] = PROD_W'(s1_ff.world_x) * PROD_W'(m00);
      px_in[1] = PROD_W'(s1_ff.world_y) * PROD_W'(m10);
      px_in[2] = PROD_W'(s1_ff.world_z) * PROD_W'(m20);
      py_in[0] = PROD_W'(s1_ff.world_x) * PROD_W'(m01);
      py_in[1] = PROD_W'(s1_ff.world_y) * PROD_W'(m11);
      py_in[2] = PROD_W'(s1_ff.world_z) * PROD_W'(m21);
      pu_in    = PROD_W'(ry) * PROD_W'(m11);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            pw_ff[i] <= pw_in[i];
            px_ff[i] <= px_in[i];
            py_ff[i] <= py_in[i];
         end
         pu_ff    <= pu_in;
         s2_op_ff <= s1_ff.op;
      end
   end

   // ---------------- s3: floor shift and partial sums ----------------
   function automatic logic signed [CLIP_W-1:0] term(input logic signed [PROD_W-1:0] p);
      return CLIP_W'($signed(p[PROD_W-1:FRAC_W]));
   endfunction

   logic signed [CLIP_W-1:0] ws_ff, wt_ff, xs_ff, xt_ff, ys_ff, yt_ff, us_ff;
   logic [1:0]               s3_op_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         ws_ff    <= term(pw_ff[0]) + term(pw_ff[1]);
         wt_ff    <= term(pw_ff[2]) + CLIP_W'(m33);
         xs_ff    <= term(px_ff[0]) + term(px_ff[1]);
         xt_ff    <= term(px_ff[2]) + CLIP_W'(m30);
         ys_ff    <= term(py_ff[0]) + term(py_ff[1]);
         yt_ff    <= term(py_ff[2]) + CLIP_W'(m31);
         us_ff    <= term(py_ff[0]) + term(pu_ff);
         s3_op_ff <= s2_op_ff;
      end
   end

   // ---------------- s4: full dot products ----------------
   logic signed [CLIP_W-1:0] w_ff;
   logic signed [CLIP_W-1:0] clip_ff [0:LANES-1];
   logic [1:0]               s4_op_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         w_ff       <= ws_ff + wt_ff;
         clip_ff[0] <= xs_ff + xt_ff;
         clip_ff[1] <= ys_ff + yt_ff;
         clip_ff[2] <= us_ff + yt_ff;
         s4_op_ff   <= s3_op_ff;
      end
   end

   // ---------------- s5: magnitudes ----------------
   logic [ABS_W-1:0] abs_ff [0:LANES-1];
   logic             neg5_ff [0:LANES-1];
   logic [ABS_W-1:0] d5_ff;
   logic             vis5_ff;
   logic [1:0]       s5_op_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < LANES; l++) begin
            neg5_ff[l] <= clip_ff[l][CLIP_W-1];
            abs_ff[l]  <= clip_ff[l][CLIP_W-1] ? ABS_W'(-clip_ff[l]) : ABS_W'(clip_ff[l]);
         end
         d5_ff    <= w_ff[ABS_W-1:0];
         vis5_ff  <= !w_ff[CLIP_W-1] && (w_ff != '0);
         s5_op_ff <= s4_op_ff;
      end
   end

   // ---------------- s6: split products by dim*2048 ----------------
   logic [SCALE_W-1:0] scale_x, scale_y;
   logic [LO_W-1:0]    lo_ff [0:LANES-1];
   logic [HI_W-1:0]    hi_ff [0:LANES-1];
   logic               neg6_ff [0:LANES-1];
   logic [ABS_W-1:0]   d6_ff;
   logic               vis6_ff;
   logic [1:0]         s6_op_ff;

   assign scale_x = {wd_ff, {DIM_SHIFT{1'b0}}};
   assign scale_y = {ht_ff, {DIM_SHIFT{1'b0}}};

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < LANES; l++) begin
            lo_ff[l] <= LO_W'(abs_ff[l][SPLIT_W-1:0]) * LO_W'((l == 0) ? scale_x : scale_y);
            hi_ff[l] <= HI_W'(abs_ff[l][ABS_W-1:SPLIT_W]) * HI_W'((l == 0) ? scale_x : scale_y);
            neg6_ff[l] <= neg5_ff[l];
         end
         d6_ff    <= d5_ff;
         vis6_ff  <= vis5_ff;
         s6_op_ff <= s5_op_ff;
      end
   end

   // ---------------- s7: dividend ----------------
   logic [NUM_W-1:0] num_ff [0:LANES-1];
   logic             neg7_ff [0:LANES-1];
   logic [ABS_W-1:0] d7_ff;
   side_type         s7_side_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < LANES; l++) begin
            num_ff[l]  <= (NUM_W'(hi_ff[l]) << SPLIT_W) + NUM_W'(lo_ff[l]);
            neg7_ff[l] <= neg6_ff[l];
         end
         d7_ff      <= d6_ff;
         s7_side_ff <= '{op: s6_op_ff, vis: vis6_ff};
      end
   end

   // ---------------- divider lanes ----------------
   logic signed [QUOT_W:0] quot [0:LANES-1];

   for (genvar g = 0; g < LANES; g++) begin : g_div
      wtsp_div u_div (
         .clock (clock),
         .en    (adv),
         .num   (num_ff[g]),
         .den   (d7_ff),
         .neg   (neg7_ff[g]),
         .quot  (quot[g])
      );
   end

   side_type side_ff [0:DIV_LAT-1];
   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= s7_side_ff;
         for (int i = 1; i < DIV_LAT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // ---------------- f1: viewport offset ----------------
   logic signed [SUM_W-1:0]  cen_x, cen_y;
   logic signed [COORD_W-1:0] sx_ff, sy_ff, uy_ff;
   side_type                  f1_side_ff;

   assign cen_x = $signed(SUM_W'({wd_ff[DIM_W-1:1], {FRAC_W{1'b0}}}));
   assign cen_y = $signed(SUM_W'({ht_ff[DIM_W-1:1], {FRAC_W{1'b0}}}));

   always_ff @(posedge clock) begin
      if (adv) begin
         sx_ff      <= sat32(cen_x + SUM_W'(quot[0]));
         sy_ff      <= sat32(cen_y - SUM_W'(quot[1]));
         uy_ff      <= sat32(cen_y - SUM_W'(quot[2]));
         f1_side_ff <= side_ff[DIV_LAT-1];
      end
   end

   // ---------------- f2: box and output register ----------------
   logic signed [SUM_W-1:0] h;
   rsp_type                 rsp_in;
   rsp_type                 rsp_ff;

   always_comb begin
      h = SUM_W'(sy_ff) - SUM_W'(uy_ff);
      rsp_in = '0;
      if (f1_side_ff.vis) begin
         rsp_in.visible  = 1'b1;
         rsp_in.screen_x = sx_ff;
         rsp_in.screen_y = sy_ff;
         if (f1_side_ff.op == OP_LABEL || f1_side_ff.op == OP_BOX) begin
            rsp_in.upper_y = uy_ff;
         end
         if (f1_side_ff.op == OP_BOX) begin
            rsp_in.box_left   = sat32(SUM_W'(sx_ff) - (h >>> 2));
            rsp_in.box_width  = sat32(h >>> 1);
            rsp_in.box_height = sat32(h);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------- assertions ----------------
   `ASSERT_IMPLY(a_hidden_zero, clock, reset,
      rsp_valid_ff && !rsp_ff.visible,
      rsp_ff.screen_x == '0 && rsp_ff.screen_y == '0 && rsp_ff.upper_y == '0,
      "hidden point carries nonzero coordinates")
   `ASSERT_IMPLY(a_box_needs_vis, clock, reset,
      rsp_valid_ff && rsp_ff.box_height != '0,
      rsp_ff.visible,
      "box present on a hidden point")
   `ASSERT_NEXT(a_stall_holds_pipe, clock, reset,
      !adv,
      $stable(vld_ff) && rsp_valid_ff,
      "pipeline moved while output stalled")

endmodule

`default_nettype wire
